// ----- src/rv64_jump_and_immediate_alu_core_defines.svh -----
// Assertion macros shared by the checker of the jump and immediate ALU core.
`ifndef RV64_JUMP_AND_IMMEDIATE_ALU_CORE_DEFINES_SVH
`define RV64_JUMP_AND_IMMEDIATE_ALU_CORE_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define RVJALU_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define RVJALU_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/rvjalu_pkg.sv -----
// Types and constants of the jump and immediate ALU core.
package rvjalu_pkg;

  localparam int XlenDefault = 64;
  localparam int DataW       = 64;

  typedef enum logic [1:0] {
    KindAlu  = 2'd0,
    KindJal  = 2'd1,
    KindJalr = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    F3Addi  = 3'd0,
    F3Slli  = 3'd1,
    F3Slti  = 3'd2,
    F3Sltiu = 3'd3,
    F3Xori  = 3'd4,
    F3Sri   = 3'd5,
    F3Ori   = 3'd6,
    F3Andi  = 3'd7
  } f3_e;

  // Upper instruction bits 31..26 of the immediate shifts
  localparam logic [5:0] ShTopLogic = 6'b000000;
  localparam logic [5:0] ShTopArith = 6'b010000;

  typedef struct packed {
    logic [1:0]       kind;
    logic [31:0]      instruction;
    logic [DataW-1:0] pc;
    logic [DataW-1:0] rs1_value;
  } in_item_t;

  typedef struct packed {
    logic [4:0]       rd_index;
    logic [DataW-1:0] rd_value;
    logic             rd_write;
    logic [DataW-1:0] next_pc;
    logic             illegal;
  } out_item_t;

  // Decoded control that travels from decode to execute
  typedef struct packed {
    logic [1:0] kind;
    logic [4:0] rd_index;
    logic [2:0] f3;
    logic [5:0] shamt;
    logic [5:0] sh_top;
  } dec_ctrl_t;

  // Control that travels from execute to the result stage
  typedef struct packed {
    logic [1:0] kind;
    logic [4:0] rd_index;
    logic       alu_bad;
  } exe_ctrl_t;

endpackage

// ----- src/rvjalu_decode.sv -----
// Decode stage: field extraction, immediates and the three address adders.
module rvjalu_decode #(
  parameter int XLEN = rvjalu_pkg::XlenDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  rvjalu_pkg::in_item_t  item_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output rvjalu_pkg::dec_ctrl_t ctrl_o,
  output logic [XLEN-1:0]       a_o,
  output logic [XLEN-1:0]       imm_o,
  output logic [XLEN-1:0]       sum_o,
  output logic [XLEN-1:0]       link_o,
  output logic [XLEN-1:0]       jtgt_o
);

  logic                  valid_q, valid_d;
  rvjalu_pkg::dec_ctrl_t ctrl_q, ctrl_d;
  logic [XLEN-1:0]       a_q, imm_q, sum_q, link_q, jtgt_q;
  logic [XLEN-1:0]       a_d, imm_d, sum_d, link_d, jtgt_d;
  logic [XLEN-1:0]       pc;
  logic [31:0]           insn;
  logic [20:0]           jimm;
  logic                  load;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;
  assign valid_d = ready_o ? valid_i : valid_q;

  assign insn = item_i.instruction;
  assign pc   = item_i.pc[XLEN-1:0];
  assign jimm = {insn[31], insn[19:12], insn[20], insn[30:21], 1'b0};

  always_comb begin
    ctrl_d.kind     = item_i.kind;
    ctrl_d.rd_index = insn[11:7];
    ctrl_d.f3       = insn[14:12];
    ctrl_d.shamt    = insn[25:20];
    ctrl_d.sh_top   = insn[31:26];
    a_d    = item_i.rs1_value[XLEN-1:0];
    imm_d  = XLEN'($signed(insn[31:20]));
    sum_d  = a_d + imm_d;
    link_d = pc + XLEN'(4);
    jtgt_d = pc + XLEN'($signed(jimm));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ctrl_q <= ctrl_d;
      a_q    <= a_d;
      imm_q  <= imm_d;
      sum_q  <= sum_d;
      link_q <= link_d;
      jtgt_q <= jtgt_d;
    end
  end

  assign valid_o = valid_q;
  assign ctrl_o  = ctrl_q;
  assign a_o     = a_q;
  assign imm_o   = imm_q;
  assign sum_o   = sum_q;
  assign link_o  = link_q;
  assign jtgt_o  = jtgt_q;

endmodule

// ----- src/rvjalu_exec.sv -----
// Execute stage: immediate ALU operations, shifts and the jump target.
module rvjalu_exec #(
  parameter int XLEN = rvjalu_pkg::XlenDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  rvjalu_pkg::dec_ctrl_t ctrl_i,
  input  logic [XLEN-1:0]       a_i,
  input  logic [XLEN-1:0]       imm_i,
  input  logic [XLEN-1:0]       sum_i,
  input  logic [XLEN-1:0]       link_i,
  input  logic [XLEN-1:0]       jtgt_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output rvjalu_pkg::exe_ctrl_t ctrl_o,
  output logic [XLEN-1:0]       alu_o,
  output logic [XLEN-1:0]       link_o,
  output logic [XLEN-1:0]       tgt_o
);

  localparam int ShCmpW = 7;

  logic                  valid_q, valid_d;
  rvjalu_pkg::exe_ctrl_t ctrl_q, ctrl_d;
  logic [XLEN-1:0]       alu_q, alu_d, link_q, tgt_q, tgt_d;
  logic                  sh_range_bad;
  logic                  load;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;
  assign valid_d = ready_o ? valid_i : valid_q;

  assign sh_range_bad = {1'b0, ctrl_i.shamt} >= ShCmpW'(XLEN);

  always_comb begin
    ctrl_d.kind     = ctrl_i.kind;
    ctrl_d.rd_index = ctrl_i.rd_index;
    ctrl_d.alu_bad  = 1'b0;
    alu_d           = '0;
    unique case (ctrl_i.f3)
      rvjalu_pkg::F3Addi:  alu_d = sum_i;
      rvjalu_pkg::F3Slli: begin
        if (ctrl_i.sh_top != rvjalu_pkg::ShTopLogic || sh_range_bad) begin
          ctrl_d.alu_bad = 1'b1;
        end else begin
          alu_d = a_i << ctrl_i.shamt;
        end
      end
      rvjalu_pkg::F3Slti:  alu_d = XLEN'($signed(a_i) < $signed(imm_i));
      rvjalu_pkg::F3Sltiu: alu_d = XLEN'(a_i < imm_i);
      rvjalu_pkg::F3Xori:  alu_d = a_i ^ imm_i;
      rvjalu_pkg::F3Sri: begin
        priority if (sh_range_bad) begin
          ctrl_d.alu_bad = 1'b1;
        end else if (ctrl_i.sh_top == rvjalu_pkg::ShTopLogic) begin
          alu_d = a_i >> ctrl_i.shamt;
        end else if (ctrl_i.sh_top == rvjalu_pkg::ShTopArith) begin
          alu_d = $unsigned($signed(a_i) >>> ctrl_i.shamt);
        end else begin
          ctrl_d.alu_bad = 1'b1;
        end
      end
      rvjalu_pkg::F3Ori:   alu_d = a_i | imm_i;
      rvjalu_pkg::F3Andi:  alu_d = a_i & imm_i;
    endcase
    // JALR drops bit 0 of rs1 + imm; JAL takes pc + J-immediate
    if (ctrl_i.kind == rvjalu_pkg::KindJalr) begin
      tgt_d = {sum_i[XLEN-1:1], 1'b0};
    end else begin
      tgt_d = jtgt_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ctrl_q <= ctrl_d;
      alu_q  <= alu_d;
      link_q <= link_i;
      tgt_q  <= tgt_d;
    end
  end

  assign valid_o = valid_q;
  assign ctrl_o  = ctrl_q;
  assign alu_o   = alu_q;
  assign link_o  = link_q;
  assign tgt_o   = tgt_q;

endmodule

// ----- src/rvjalu_result.sv -----
// Result stage: select by kind, apply the illegal override, hold the output item.
module rvjalu_result #(
  parameter int XLEN = rvjalu_pkg::XlenDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  rvjalu_pkg::exe_ctrl_t ctrl_i,
  input  logic [XLEN-1:0]       alu_i,
  input  logic [XLEN-1:0]       link_i,
  input  logic [XLEN-1:0]       tgt_i,
  output logic                  valid_o,
  input  logic                  stall_i,
  output rvjalu_pkg::out_item_t item_o
);

  localparam int DataW = rvjalu_pkg::DataW;

  logic                  valid_q, valid_d;
  rvjalu_pkg::out_item_t item_q, item_d;
  logic                  load;

  assign ready_o = !valid_q || !stall_i;
  assign load    = valid_i && ready_o;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_comb begin
    item_d.rd_index = ctrl_i.rd_index;
    item_d.rd_value = '0;
    item_d.rd_write = 1'b0;
    item_d.next_pc  = DataW'(link_i);
    item_d.illegal  = 1'b0;
    unique case (ctrl_i.kind)
      rvjalu_pkg::KindAlu: begin
        item_d.rd_value = DataW'(alu_i);
        item_d.rd_write = !ctrl_i.alu_bad;
        item_d.illegal  = ctrl_i.alu_bad;
      end
      rvjalu_pkg::KindJal, rvjalu_pkg::KindJalr: begin
        item_d.rd_value = DataW'(link_i);
        item_d.rd_write = 1'b1;
        item_d.next_pc  = DataW'(tgt_i);
      end
      default: begin
        item_d.illegal = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ----- src/rv64_jump_and_immediate_alu_core.sv -----
// Top level of the RV64I immediate ALU and JAL/JALR execute pipeline.
// An accepted item passes the decode, execute and result registers before its result item is on the output.
// Throughput: 1 item per cycle while the output is not stalled; the three stage registers each hold one item.
// Stall from the output ripples back combinationally through the stage ready chain.
// Reset (rst_ni low, async) clears the stage valid bits; payload registers keep junk.
// XLEN sets the datapath width; results are zero-extended to the 64-bit fields.
module rv64_jump_and_immediate_alu_core #(
  parameter int XLEN = rvjalu_pkg::XlenDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  rvjalu_pkg::in_item_t  in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output rvjalu_pkg::out_item_t out_item_o
);

  // Decode -> execute
  logic                  dec_valid, dec_ready;
  rvjalu_pkg::dec_ctrl_t dec_ctrl;
  logic [XLEN-1:0]       dec_a, dec_imm, dec_sum, dec_link, dec_jtgt;

  // Execute -> result
  logic                  exe_valid, exe_ready;
  rvjalu_pkg::exe_ctrl_t exe_ctrl;
  logic [XLEN-1:0]       exe_alu, exe_link, exe_tgt;

  logic                  in_ready;

  // Stage 1: pull out rd, func3, shift fields, build both immediates and
  // run the adders (rs1 + I-imm, pc + 4, pc + J-imm) in parallel.
  rvjalu_decode #(
    .XLEN(XLEN)
  ) u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready),
    .item_i  (in_item_i),
    .valid_o (dec_valid),
    .ready_i (dec_ready),
    .ctrl_o  (dec_ctrl),
    .a_o     (dec_a),
    .imm_o   (dec_imm),
    .sum_o   (dec_sum),
    .link_o  (dec_link),
    .jtgt_o  (dec_jtgt)
  );

  // Stage 2: compares, logic ops and the barrel shifter; flag reserved
  // shift encodings; pick the jump target (JALR clears bit 0).
  rvjalu_exec #(
    .XLEN(XLEN)
  ) u_exec (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dec_valid),
    .ready_o (dec_ready),
    .ctrl_i  (dec_ctrl),
    .a_i     (dec_a),
    .imm_i   (dec_imm),
    .sum_i   (dec_sum),
    .link_i  (dec_link),
    .jtgt_i  (dec_jtgt),
    .valid_o (exe_valid),
    .ready_i (exe_ready),
    .ctrl_o  (exe_ctrl),
    .alu_o   (exe_alu),
    .link_o  (exe_link),
    .tgt_o   (exe_tgt)
  );

  // Stage 3: merge by kind, drop the write on an illegal item, and hold
  // the finished item in the output register while the consumer stalls.
  rvjalu_result #(
    .XLEN(XLEN)
  ) u_result (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (exe_valid),
    .ready_o (exe_ready),
    .ctrl_i  (exe_ctrl),
    .alu_i   (exe_alu),
    .link_i  (exe_link),
    .tgt_i   (exe_tgt),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .item_o  (out_item_o)
  );

  // Stall the producer only when every stage is full and the output is held.
  assign in_stall_o = !in_ready;

endmodule

// ----- src/rvjalu_checker.sv -----
// Port-level checker of the jump and immediate ALU core, bound to the top level.
`include "rv64_jump_and_immediate_alu_core_defines.svh"

module rvjalu_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input rvjalu_pkg::in_item_t  in_item_i,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input rvjalu_pkg::out_item_t out_item_o
);

  // Output register is empty from the edge after any edge that sees reset.
  `RVJALU_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |=> !out_valid_o, "output valid in reset")

  // Input stalls only when the held output is itself stalled.
  `RVJALU_ASSERT(a_stall_source, clk_i, rst_ni, in_stall_o |-> (out_valid_o && out_stall_i), "input stall without output stall")

  // An illegal item writes nothing and carries a zero value.
  `RVJALU_ASSERT(a_illegal_quiet, clk_i, rst_ni, (out_valid_o && out_item_o.illegal) |-> (!out_item_o.rd_write && (out_item_o.rd_value == '0)), "illegal item writes")

  // Every legal item writes back.
  `RVJALU_ASSERT(a_legal_writes, clk_i, rst_ni, (out_valid_o && !out_item_o.illegal) |-> out_item_o.rd_write, "legal item without write")

  // A stalled result item holds.
  `RVJALU_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_item_o)), "stalled item changed")

endmodule

bind rv64_jump_and_immediate_alu_core rvjalu_checker u_rvjalu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
